// File: rtl/salht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salht_pkg
// shared widths, access kind codes and field types for the lru tag tracker
// ----------------------------------------------------------------------------
package salht_pkg;

   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 64;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [STAMP_W-1:0] stamp_type;

   // access kind carried in tuser
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_STORE = 1'b1;

endpackage

`default_nettype wire

// File: rtl/set_assoc_lru_hit_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_hit_tracker
// tag-only set-associative lookup with lru replacement, one hit flag per access
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata                              tuser
//   req      in   [31:0] addr, [95:32] time_stamp   [0] func
//   rsp      out  [0] hit, [7:1] zero               -
//
// one transfer per cycle sustained while rsp_tready stays high; rsp_tvalid rises once
// the request has passed the lookup stage registers and the result register (set row
// read at the transfer, then compare and write-back into rsp reg)
// after reset a clearing pass over all SET_COUNT sets zeroes the valid bits,
// req_tready stays low meanwhile
// a back-to-back access to the same set sees the row just written through
// the memory's read bypass
// a stalled rsp holds the lookup stage; req keeps flowing while it has room
//
module set_assoc_lru_hit_tracker #(
   parameter int LINE_BYTES = 8,
   parameter int SET_COUNT  = 64,
   parameter int WAY_COUNT  = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // addr [31:0], time_stamp [95:32]
   input  wire logic [0:0]  req_tuser,   // func [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // hit [0], zero [7:1]
);
   import salht_pkg::*;

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int SETB   = $clog2(SET_COUNT);
   localparam int SET_W  = (SETB > 0) ? SETB : 1;
   localparam int TAG_W  = ADDR_W - OFF_W - SETB;
   localparam int ROW_W  = WAY_COUNT * (1 + TAG_W + STAMP_W);

   // request fields
   addr_type   req_addr;
   stamp_type  req_stamp;
   logic [SET_W-1:0] req_set;

   // lookup stage registers
   logic             s1_valid_ff;
   logic             s1_func_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic [SET_W-1:0] s1_set_ff;
   stamp_type        s1_stamp_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_hit_ff;

   // clearing pass
   logic             clear_active_ff;
   logic [SET_W-1:0] clear_idx_ff;

   logic advance;
   logic accept;

   // memory row and lookup outputs
   logic [ROW_W-1:0]                 rd_row;
   logic [ROW_W-1:0]                 upd_row;
   logic [ROW_W-1:0]                 wr_row;
   logic [SET_W-1:0]                 wr_set;
   logic                             wr_en;
   logic [WAY_COUNT-1:0]             row_valid;
   logic [WAY_COUNT-1:0][TAG_W-1:0]  row_tag;
   stamp_type [WAY_COUNT-1:0]        row_stamp;
   logic                             lk_hit;
   logic                             lk_wr_en;
   logic [WAY_COUNT-1:0]             new_valid;
   logic [WAY_COUNT-1:0][TAG_W-1:0]  new_tag;
   stamp_type [WAY_COUNT-1:0]        new_stamp;

   assign req_addr  = req_tdata[31:0];
   assign req_stamp = req_tdata[95:32];
   assign req_set   = SET_W'((req_addr >> OFF_W) & addr_type'(SET_COUNT - 1));

   // handshake: lookup stage moves when the result register is empty or its result is taken
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_active_ff && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_idx_ff    <= '0;
      end else if (clear_active_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_idx_ff == SET_W'(SET_COUNT - 1)) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // payload of the lookup stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= req_tuser[0];
         s1_tag_ff   <= TAG_W'(req_addr >> (OFF_W + SETB));
         s1_set_ff   <= req_set;
         s1_stamp_ff <= req_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= lk_hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_hit_ff};

   // row layout: valid bits low, then tags, then stamps
   assign row_valid = rd_row[WAY_COUNT-1:0];
   assign row_tag   = rd_row[WAY_COUNT +: WAY_COUNT*TAG_W];
   assign row_stamp = rd_row[WAY_COUNT*(1+TAG_W) +: WAY_COUNT*STAMP_W];
   assign upd_row   = {new_stamp, new_tag, new_valid};

   // clearing pass writes an all-invalid row
   assign wr_en  = clear_active_ff || (advance && lk_wr_en);
   assign wr_set = clear_active_ff ? clear_idx_ff : s1_set_ff;
   assign wr_row = clear_active_ff ? '0 : upd_row;

   salht_row_ram #(
      .DEPTH  (SET_COUNT),
      .WIDTH  (ROW_W),
      .ADDR_W (SET_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_set),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   salht_lookup #(
      .WAY_COUNT (WAY_COUNT),
      .TAG_W     (TAG_W)
   ) u_lookup (
      .row_valid (row_valid),
      .row_tag   (row_tag),
      .row_stamp (row_stamp),
      .tag       (s1_tag_ff),
      .func      (s1_func_ff),
      .stamp     (s1_stamp_ff),
      .hit       (lk_hit),
      .wr_en     (lk_wr_en),
      .new_valid (new_valid),
      .new_tag   (new_tag),
      .new_stamp (new_stamp)
   );

endmodule

`default_nettype wire

// File: rtl/salht_row_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salht_row_ram
// one-write one-read row memory, registered read with write-to-read bypass
// ----------------------------------------------------------------------------
module salht_row_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-address write in the read cycle returns the new row
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/salht_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salht_lookup
// tag compare, fill/victim choice and updated row for one set
// ----------------------------------------------------------------------------
module salht_lookup #(
   parameter int WAY_COUNT = 4,
   parameter int TAG_W     = 23
) (
   input  wire logic [WAY_COUNT-1:0]            row_valid,
   input  wire logic [WAY_COUNT-1:0][TAG_W-1:0] row_tag,
   input  wire salht_pkg::stamp_type [WAY_COUNT-1:0] row_stamp,
   input  wire logic [TAG_W-1:0]                tag,
   input  wire logic                            func,
   input  wire salht_pkg::stamp_type            stamp,
   output logic                                 hit,
   output logic                                 wr_en,
   output logic [WAY_COUNT-1:0]                 new_valid,
   output logic [WAY_COUNT-1:0][TAG_W-1:0]      new_tag,
   output salht_pkg::stamp_type [WAY_COUNT-1:0] new_stamp
);
   import salht_pkg::*;

   localparam int LVL   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int POW   = 1 << LVL;
   localparam int WAY_W = LVL;

   logic [WAY_COUNT-1:0] match;
   logic [WAY_COUNT-1:0] hit_sel;
   logic [WAY_COUNT-1:0] inv_sel;
   logic [WAY_COUNT-1:0] lru_sel;
   logic [WAY_COUNT-1:0] fill_sel;
   logic                 any_invalid;
   logic                 found_hit;
   logic                 found_inv;

   stamp_type        node_stamp [LVL+1][POW];
   logic [WAY_W-1:0] node_idx   [LVL+1][POW];
   logic             node_live  [LVL+1][POW];

   // hit and first invalid way, lowest index wins
   always_comb begin
      found_hit = 1'b0;
      found_inv = 1'b0;
      hit_sel   = '0;
      inv_sel   = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         match[w] = row_valid[w] && (row_tag[w] == tag);
         if (match[w] && !found_hit) begin
            hit_sel[w] = 1'b1;
            found_hit  = 1'b1;
         end
         if (!row_valid[w] && !found_inv) begin
            inv_sel[w] = 1'b1;
            found_inv  = 1'b1;
         end
      end
      hit         = found_hit;
      any_invalid = found_inv;
   end

   // oldest stamp by a compare tree, left side kept on a tie
   always_comb begin
      for (int l = 0; l <= LVL; l++) begin
         for (int n = 0; n < POW; n++) begin
            node_stamp[l][n] = '1;
            node_idx[l][n]   = '0;
            node_live[l][n]  = 1'b0;
         end
      end
      for (int n = 0; n < POW; n++) begin
         if (n < WAY_COUNT) begin
            node_stamp[0][n] = row_stamp[n];
            node_live[0][n]  = 1'b1;
         end
         node_idx[0][n] = WAY_W'(n);
      end
      for (int l = 1; l <= LVL; l++) begin
         for (int n = 0; n < (POW >> l); n++) begin
            if (node_live[l-1][2*n+1] && (node_stamp[l-1][2*n+1] < node_stamp[l-1][2*n])) begin
               node_stamp[l][n] = node_stamp[l-1][2*n+1];
               node_idx[l][n]   = node_idx[l-1][2*n+1];
            end else begin
               node_stamp[l][n] = node_stamp[l-1][2*n];
               node_idx[l][n]   = node_idx[l-1][2*n];
            end
            node_live[l][n] = node_live[l-1][2*n];
         end
      end
      for (int w = 0; w < WAY_COUNT; w++) begin
         lru_sel[w] = (node_idx[LVL][0] == WAY_W'(w));
      end
   end

   assign fill_sel = any_invalid ? inv_sel : lru_sel;
   assign wr_en    = hit || (func == FUNC_LOAD);

   // updated row: stamp refresh on hit, fill on load miss
   always_comb begin
      new_valid = row_valid;
      new_tag   = row_tag;
      new_stamp = row_stamp;
      for (int w = 0; w < WAY_COUNT; w++) begin
         if (hit) begin
            if (hit_sel[w]) begin
               new_stamp[w] = stamp;
            end
         end else if (fill_sel[w]) begin
            new_valid[w] = 1'b1;
            new_tag[w]   = tag;
            new_stamp[w] = stamp;
         end
      end
   end

endmodule

`default_nettype wire
